// ===== design/rabs_pkg.sv =====
// Package for the rotated-area bounding size unit: sizes, angle constants,
// stage structs and the elaboration-time builder of the quarter-wave sine ROM.
// No dependencies.
package rabs_pkg;

  localparam int ANGLE_FRAC_BITS = 4;   // angle fraction bits, 0..8
  localparam int SCALE_BITS      = 15;  // Q format of |sin| and |cos|, 8..16
  localparam int SIZE_BITS       = 16;  // used bits of width and height, 8..16

  // Field widths of the channels
  localparam int ANGLE_W = 14;
  localparam int SIZE_W  = 16;
  localparam int OUT_W   = 17;

  // Angle units
  localparam int TURN    = 360 << ANGLE_FRAC_BITS;
  localparam int HALF    = 180 << ANGLE_FRAC_BITS;
  localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam int IDX_W   = $clog2(QUARTER + 1);

  // Angle folding: bias by whole turns so the angle is never negative
  localparam int ANGLE_MAG = 1 << (ANGLE_W - 1);
  localparam int BIAS      = TURN * ((ANGLE_MAG + TURN - 1) / TURN);
  localparam int U_MAX     = ANGLE_MAG - 1 + BIAS;
  localparam int U_W       = $clog2(U_MAX + 1);
  localparam int NSTEP     = $clog2(U_MAX / TURN + 1);

  // Datapath widths
  localparam int SINE_W = SCALE_BITS + 1;
  localparam int PROD_W = SINE_W + SIZE_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int EXT_W  = (SUM_W > SCALE_BITS + OUT_W) ? SUM_W : SCALE_BITS + OUT_W;

  // Series constants, Q60 radians
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60    = 64'h1000000000000000;
  localparam logic [63:0] DEG_DIV    = 64'(HALF);
  localparam logic [63:0] STEP_WHOLE = PI_Q60 / DEG_DIV;
  localparam logic [63:0] STEP_FRAC  = PI_Q60 % DEG_DIV;
  localparam int          SERIES_N   = 30;
  localparam int          SUM_BIAS_SHIFT = 9;

  typedef logic [SINE_W-1:0] sine_rom_t [0:QUARTER];

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
  } fold_t;

  typedef struct packed {
    logic [SINE_W-1:0]    sin_v;
    logic [SINE_W-1:0]    cos_v;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
  } trig_t;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // truncating quotient by long division; only evaluated while building the ROM
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(sin(k / 2^ANGLE_FRAC_BITS degrees) * 2^SCALE_BITS) by Taylor series
  function automatic logic [SINE_W-1:0] quarter_sine(input int k);
    logic [63:0] x, x2, term, sum, kk, dvs;
    logic        neg;
    kk = 64'(k);
    if (k == 0) return '0;
    if (k >= QUARTER) return SINE_W'(1) << SCALE_BITS;
    if (k * 3 == QUARTER) return SINE_W'(1) << (SCALE_BITS - 1);
    x    = kk * STEP_WHOLE + udiv64(kk * STEP_FRAC, DEG_DIV);
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    neg  = 1'b1;
    for (int n = 1; n < SERIES_N; n++) begin
      if (term != 64'd0) begin
        dvs  = 64'(2 * n) * 64'(2 * n + 1);
        term = udiv64(mul_q60(term, x2), dvs);
        sum  = neg ? sum - term : sum + term;
        neg  = !neg;
      end
    end
    sum = sum + (64'd1 << SUM_BIAS_SHIFT);
    if (sum >= ONE_Q60) sum = ONE_Q60;
    sum = sum >> (60 - SCALE_BITS);
    return sum[SINE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= QUARTER; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

endpackage

// ===== design/rabs_if.sv =====
// Channel interfaces of the rotated-area bounding size unit.
// Depends on rabs_pkg for field widths.
interface rabs_in_if import rabs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_sixteenths;
  logic        [SIZE_W-1:0]  area_width;
  logic        [SIZE_W-1:0]  area_height;

  modport source (output valid, angle_sixteenths, area_width, area_height, input ready);
  modport sink   (input valid, angle_sixteenths, area_width, area_height, output ready);
endinterface

interface rabs_out_if import rabs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] rotated_cols;
  logic [OUT_W-1:0] rotated_rows;

  modport source (output valid, rotated_cols, rotated_rows, input ready);
  modport sink   (input valid, rotated_cols, rotated_rows, output ready);
endinterface

// ===== design/rabs_fold.sv =====
// Stage 1: reduces the angle to one turn and folds it into 0..90 degrees.
// Depends on rabs_pkg.
module rabs_fold import rabs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [ANGLE_W-1:0] angle_i,
  input  logic        [SIZE_W-1:0]  width_i,
  input  logic        [SIZE_W-1:0]  height_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output fold_t                     data_o
);

  logic            vld_r;
  fold_t           data_r;
  fold_t           data_nxt;
  logic signed [U_W:0] ang_ext;
  logic signed [U_W:0] biased;
  logic [U_W-1:0]  rem;
  logic [U_W-1:0]  hrem;

  always_comb begin
    ang_ext = (U_W + 1)'(angle_i);
    biased  = ang_ext + (U_W + 1)'(BIAS);
    rem     = biased[U_W-1:0];
    // restoring reduction by turns, largest multiple first
    for (int j = NSTEP - 1; j >= 0; j--) begin
      if (rem >= U_W'(TURN << j)) rem = rem - U_W'(TURN << j);
    end
    hrem = (rem >= U_W'(HALF)) ? rem - U_W'(HALF) : rem;
    if (hrem > U_W'(QUARTER)) hrem = U_W'(HALF) - hrem;
    data_nxt.idx = hrem[IDX_W-1:0];
    data_nxt.w   = width_i[SIZE_BITS-1:0];
    data_nxt.h   = height_i[SIZE_BITS-1:0];
  end

  assign ready_o = !vld_r || ready_i;
  assign valid_o = vld_r;
  assign data_o  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== design/rabs_sine_rom.sv =====
// Stage 2: quarter-wave sine ROM, two registered reads (sin and cos).
// Depends on rabs_pkg for the ROM contents.
module rabs_sine_rom import rabs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_i,
  output logic  ready_o,
  input  fold_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output trig_t data_o
);

  localparam sine_rom_t SineRom = build_sine_rom();

  logic             vld_r;
  trig_t            data_r;
  logic [IDX_W-1:0] cos_idx;

  assign cos_idx = IDX_W'(QUARTER) - data_i.idx;
  assign ready_o = !vld_r || ready_i;
  assign valid_o = vld_r;
  assign data_o  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r.sin_v <= SineRom[data_i.idx];
      data_r.cos_v <= SineRom[cos_idx];
      data_r.w     <= data_i.w;
      data_r.h     <= data_i.h;
    end
  end

endmodule

// ===== design/rabs_scale.sv =====
// Stages 3 and 4: four products, then the two sums rounded up to pixels.
// Depends on rabs_pkg.
module rabs_scale import rabs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  output logic             ready_o,
  input  trig_t            data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [OUT_W-1:0] cols_o,
  output logic [OUT_W-1:0] rows_o
);

  localparam logic [EXT_W-1:0] Round = (EXT_W'(1) << SCALE_BITS) - EXT_W'(1);

  logic              mul_vld_r;
  logic              mul_rdy;
  logic [PROD_W-1:0] cw_r, sh_r, sw_r, ch_r;
  logic              sum_vld_r;
  logic [OUT_W-1:0]  cols_r, rows_r;
  logic [EXT_W-1:0]  cols_sum, rows_sum;

  assign ready_o = !mul_vld_r || mul_rdy;
  assign mul_rdy = !sum_vld_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      sum_vld_r <= 1'b0;
    end else begin
      if (ready_o) mul_vld_r <= valid_i;
      if (mul_rdy) sum_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      cw_r <= PROD_W'(data_i.cos_v) * PROD_W'(data_i.w);
      sh_r <= PROD_W'(data_i.sin_v) * PROD_W'(data_i.h);
      sw_r <= PROD_W'(data_i.sin_v) * PROD_W'(data_i.w);
      ch_r <= PROD_W'(data_i.cos_v) * PROD_W'(data_i.h);
    end
  end

  assign cols_sum = EXT_W'(cw_r) + EXT_W'(sh_r) + Round;
  assign rows_sum = EXT_W'(sw_r) + EXT_W'(ch_r) + Round;

  always_ff @(posedge clk) begin
    if (mul_rdy && mul_vld_r) begin
      cols_r <= cols_sum[SCALE_BITS +: OUT_W];
      rows_r <= rows_sum[SCALE_BITS +: OUT_W];
    end
  end

  assign valid_o = sum_vld_r;
  assign cols_o  = cols_r;
  assign rows_o  = rows_r;

endmodule

// ===== design/rotated_area_bounding_size_unit.sv =====
// Channel   Dir  Handshake     Payload
// in_chan   in   valid/ready   angle_sixteenths, area_width, area_height
// out_chan  out  valid/ready   rotated_cols, rotated_rows
//
// One transfer per cycle in and out; stages are fold, sine ROM read,
// multiply, sum and round up. The ROM has 1441 entries read at two addresses
// each cycle. Synchronous active-low reset clears only the stage valid bits.
// A stall on out_chan holds every full stage; empty stages still fill.
// Depends on rabs_pkg, rabs_if, rabs_fold, rabs_sine_rom, rabs_scale.
module rotated_area_bounding_size_unit import rabs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rabs_in_if.sink   in_chan,
  rabs_out_if.source out_chan
);

  logic  fold_vld, fold_rdy;
  fold_t fold_data;
  logic  trig_vld, trig_rdy;
  trig_t trig_data;

  rabs_fold u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_chan.valid),
    .ready_o  (in_chan.ready),
    .angle_i  (in_chan.angle_sixteenths),
    .width_i  (in_chan.area_width),
    .height_i (in_chan.area_height),
    .valid_o  (fold_vld),
    .ready_i  (fold_rdy),
    .data_o   (fold_data)
  );

  rabs_sine_rom u_rom (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (fold_vld),
    .ready_o (fold_rdy),
    .data_i  (fold_data),
    .valid_o (trig_vld),
    .ready_i (trig_rdy),
    .data_o  (trig_data)
  );

  rabs_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (trig_vld),
    .ready_o (trig_rdy),
    .data_i  (trig_data),
    .valid_o (out_chan.valid),
    .ready_i (out_chan.ready),
    .cols_o  (out_chan.rotated_cols),
    .rows_o  (out_chan.rotated_rows)
  );

  // a ready sink never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input blocked while sink ready");

  // an input transfer reaches the output while out_chan stays ready behind it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) ##1 out_chan.ready ##1 out_chan.ready
      ##1 out_chan.ready |=> out_chan.valid)
    else $error("result missing after pipeline latency");

  // nothing leaves the block right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_chan.valid)
    else $error("output valid right after reset");

endmodule
